>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition");

`endif

>>> sv/lsac_pkg.sv
package lsac_pkg;
  // Fixed field widths
  localparam int unsigned KEY_W = 32;
  localparam int unsigned EVC_W = 7;
  // Register map
  localparam int unsigned REG_BYTE_CAPACITY = 0;
  localparam int unsigned CAP_RESET = 1048576;
endpackage

>>> sv/lsac_if.sv
interface cache_req_if #(parameter int unsigned SIZE_BITS = 24);
  import lsac_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [KEY_W-1:0]     object_key;
  logic [SIZE_BITS-1:0] object_size;
  modport source (output valid, object_key, object_size, input ready);
  modport sink   (input valid, object_key, object_size, output ready);
endinterface

interface cache_rsp_if #(parameter int unsigned SIZE_BITS = 24);
  import lsac_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic                 stored;
  logic [EVC_W-1:0]     evicted_count;
  logic [SIZE_BITS-1:0] used_bytes;
  modport source (output valid, hit, stored, evicted_count, used_bytes, input ready);
  modport sink   (input valid, hit, stored, evicted_count, used_bytes, output ready);
endinterface

>>> sv/lsac_list_ram.sv
module lsac_list_ram #(
  parameter int unsigned ENTRIES   = 64,
  parameter int unsigned SIZE_BITS = 24,
  parameter int unsigned AW        = 6
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [lsac_pkg::KEY_W-1:0]   wkey_i,
  input  logic [SIZE_BITS-1:0]         wsize_i,
  input  logic [AW-1:0]                raddr_i,
  output logic [lsac_pkg::KEY_W-1:0]   rkey_o,
  output logic [SIZE_BITS-1:0]         rsize_o
);
  import lsac_pkg::*;

  // Recency list storage, one key/size pair per position
  logic [KEY_W-1:0]     key_mem  [ENTRIES];
  logic [SIZE_BITS-1:0] size_mem [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem[waddr_i]  <= wkey_i;
      size_mem[waddr_i] <= wsize_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rkey_o  <= key_mem[raddr_i];
    rsize_o <= size_mem[raddr_i];
  end
endmodule

>>> sv/lsac_ctrl.sv
module lsac_ctrl #(
  parameter int unsigned ENTRIES   = 64,
  parameter int unsigned SIZE_BITS = 24,
  parameter int unsigned AW        = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [SIZE_BITS-1:0]         capacity_i,
  cache_req_if.sink                    req_i,
  cache_rsp_if.source                  rsp_o,
  output logic                         we_o,
  output logic [AW-1:0]                waddr_o,
  output logic [lsac_pkg::KEY_W-1:0]   wkey_o,
  output logic [SIZE_BITS-1:0]         wsize_o,
  output logic [AW-1:0]                raddr_o,
  input  logic [lsac_pkg::KEY_W-1:0]   rkey_i,
  input  logic [SIZE_BITS-1:0]         rsize_i
);
  import lsac_pkg::*;
`include "assert_macros.svh"

  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned EW = (CW > EVC_W) ? CW : EVC_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOOK, ST_SHIFT, ST_PUT, ST_MISS, ST_EVCHK, ST_EVSUB, ST_INS, ST_FIN
  } state_e;

  state_e               state_q;
  logic [AW-1:0]        head_q;
  logic [CW-1:0]        cnt_q;
  logic [CW-1:0]        pos_q;
  logic [SIZE_BITS-1:0] bytes_q;
  logic [EW-1:0]        ev_q;
  logic [KEY_W-1:0]     key_q;
  logic [SIZE_BITS-1:0] size_q;
  logic [KEY_W-1:0]     mkey_q;
  logic [SIZE_BITS-1:0] msize_q;
  logic                 hit_q;
  logic                 stored_q;
  logic                 ov_q;
  logic                 ohit_q;
  logic                 ostored_q;
  logic [EVC_W-1:0]     oev_q;
  logic [SIZE_BITS-1:0] obytes_q;

  // Physical address of a list position in the circular buffer
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [AW:0] off);
    logic [AW:0] s;
    s = {1'b0, head} + off;
    if (s >= (AW+1)'(ENTRIES)) s = s - (AW+1)'(ENTRIES);
    return s[AW-1:0];
  endfunction

  logic [CW:0]        pos_p1;
  logic [CW:0]        pos_p2;
  logic [CW:0]        cnt_x;
  logic [SIZE_BITS:0] need;
  logic               over;
  logic               match;
  logic               load;

  // Shared byte adder and compare
  assign need   = {1'b0, bytes_q} + {1'b0, size_q};
  assign over   = need > {1'b0, capacity_i};
  assign pos_p1 = {1'b0, pos_q} + (CW+1)'(1);
  assign pos_p2 = {1'b0, pos_q} + (CW+1)'(2);
  assign cnt_x  = {1'b0, cnt_q};
  assign match  = rkey_i == key_q;
  assign load   = (state_q == ST_FIN) && (!ov_q || rsp_o.ready);

  assign req_i.ready        = state_q == ST_IDLE;
  assign rsp_o.valid        = ov_q;
  assign rsp_o.hit          = ohit_q;
  assign rsp_o.stored       = ostored_q;
  assign rsp_o.evicted_count = oev_q;
  assign rsp_o.used_bytes   = obytes_q;

  // Memory port steering
  always_comb begin
    raddr_o = head_q;
    we_o    = 1'b0;
    waddr_o = phys(head_q, (AW+1)'(pos_q));
    wkey_o  = rkey_i;
    wsize_o = rsize_i;
    case (state_q)
      ST_LOOK:  raddr_o = phys(head_q, (AW+1)'(pos_p1));
      ST_SHIFT: begin
        raddr_o = phys(head_q, (AW+1)'(pos_p2));
        we_o    = 1'b1;
      end
      ST_PUT: begin
        we_o    = 1'b1;
        waddr_o = phys(head_q, (AW+1)'(cnt_x - (CW+1)'(1)));
        wkey_o  = mkey_q;
        wsize_o = msize_q;
      end
      ST_INS: begin
        we_o    = 1'b1;
        waddr_o = phys(head_q, (AW+1)'(cnt_x));
        wkey_o  = key_q;
        wsize_o = size_q;
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      cnt_q     <= '0;
      pos_q     <= '0;
      bytes_q   <= '0;
      ev_q      <= '0;
      key_q     <= '0;
      size_q    <= '0;
      mkey_q    <= '0;
      msize_q   <= '0;
      hit_q     <= 1'b0;
      stored_q  <= 1'b0;
      ov_q      <= 1'b0;
      ohit_q    <= 1'b0;
      ostored_q <= 1'b0;
      oev_q     <= '0;
      obytes_q  <= '0;
    end else begin
      // Output register valid: set on load, cleared when taken
      if (load) begin
        ov_q <= 1'b1;
      end else if (ov_q && rsp_o.ready) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (req_i.valid) begin
            key_q    <= req_i.object_key;
            size_q   <= req_i.object_size;
            pos_q    <= '0;
            ev_q     <= '0;
            hit_q    <= 1'b0;
            stored_q <= 1'b0;
            state_q  <= (cnt_q == '0) ? ST_MISS : ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (match) begin
            hit_q    <= 1'b1;
            stored_q <= 1'b1;
            mkey_q   <= rkey_i;
            msize_q  <= rsize_i;
            state_q  <= (pos_p1 == cnt_x) ? ST_FIN : ST_SHIFT;
          end else if (pos_p1 == cnt_x) begin
            state_q <= ST_MISS;
          end else begin
            pos_q <= pos_p1[CW-1:0];
          end
        end
        ST_SHIFT: begin
          pos_q <= pos_p1[CW-1:0];
          if (pos_p2 == cnt_x) state_q <= ST_PUT;
        end
        ST_PUT: state_q <= ST_FIN;
        ST_MISS: begin
          if (size_q > capacity_i) begin
            ev_q    <= EW'(cnt_q);
            cnt_q   <= '0;
            bytes_q <= '0;
            state_q <= ST_FIN;
          end else begin
            state_q <= ST_EVCHK;
          end
        end
        ST_EVCHK: begin
          if (cnt_q != '0 && (cnt_x == (CW+1)'(ENTRIES) || over)) state_q <= ST_EVSUB;
          else state_q <= ST_INS;
        end
        ST_EVSUB: begin
          bytes_q <= bytes_q - rsize_i;
          head_q  <= phys(head_q, (AW+1)'(1));
          cnt_q   <= cnt_q - CW'(1);
          ev_q    <= ev_q + EW'(1);
          state_q <= ST_EVCHK;
        end
        ST_INS: begin
          cnt_q    <= cnt_q + CW'(1);
          bytes_q  <= need[SIZE_BITS-1:0];
          stored_q <= 1'b1;
          state_q  <= ST_FIN;
        end
        ST_FIN: begin
          if (load) begin
            ohit_q    <= hit_q;
            ostored_q <= stored_q;
            oev_q     <= ev_q[EVC_W-1:0];
            obytes_q  <= bytes_q;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_NEVER(a_cnt_range, clk_i, rst_ni, cnt_x > (CW+1)'(ENTRIES))
  `ASSERT_CLK(a_rsp_hold, clk_i, rst_ni, (ov_q && !rsp_o.ready) |=> ov_q)
  `ASSERT_CLK(a_hit_no_evict, clk_i, rst_ni, (load && hit_q) |-> (ev_q == '0))
endmodule

>>> sv/size_aware_lru_cache_top.sv
// Size-aware LRU cache with a byte budget.
// Requests arrive on req_i (object_key, object_size) with a valid/ready
// handshake; one result per request leaves on rsp_o (hit, stored,
// evicted_count, used_bytes). byte_capacity is written over the APB port
// at address 0 and read back there; write it only while the block is idle.
// Recency is a circular list in one memory with a registered read port;
// a single sequencer and byte adder serve lookup, reordering and eviction.
// Lookup walks the list one position a cycle; a hit then moves later
// entries down one a cycle and writes the hit entry at the tail; a miss
// evicts from the head until the object fits and inserts it at the tail,
// but an oversize object empties the cache. One item is in work at a time.
// The result sits in an output register; the next request is taken while
// it waits, but a stalled receiver holds the block before its next result.
// Reset empties the cache at once and sets byte_capacity to 1048576.
module size_aware_lru_cache_top #(
  parameter int unsigned ENTRIES   = 64,
  parameter int unsigned SIZE_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  cache_req_if.sink                            req_i,
  cache_rsp_if.source                          rsp_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [((SIZE_BITS > 32) ? 4 : 3)-1:0] paddr,
  input  logic [((SIZE_BITS > 32) ? 64 : 32)-1:0] pwdata,
  output logic [((SIZE_BITS > 32) ? 64 : 32)-1:0] prdata,
  output logic                                 pready
);
  import lsac_pkg::*;

  localparam int unsigned AW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned DW  = (SIZE_BITS > 32) ? 64 : 32;
  localparam int unsigned PAW = (SIZE_BITS > 32) ? 4 : 3;

  logic [SIZE_BITS-1:0] cap_q;
  logic                 sel_cap;

  // Configuration register
  assign pready  = 1'b1;
  assign sel_cap = paddr[PAW-1] == 1'(REG_BYTE_CAPACITY);
  assign prdata  = sel_cap ? DW'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= SIZE_BITS'(CAP_RESET);
    end else if (psel && penable && pwrite && sel_cap) begin
      cap_q <= pwdata[SIZE_BITS-1:0];
    end
  end

  logic                 we;
  logic [AW-1:0]        waddr;
  logic [KEY_W-1:0]     wkey;
  logic [SIZE_BITS-1:0] wsize;
  logic [AW-1:0]        raddr;
  logic [KEY_W-1:0]     rkey;
  logic [SIZE_BITS-1:0] rsize;

  lsac_ctrl #(.ENTRIES(ENTRIES), .SIZE_BITS(SIZE_BITS), .AW(AW)) u_ctrl (
    .clk_i, .rst_ni, .capacity_i(cap_q), .req_i, .rsp_o,
    .we_o(we), .waddr_o(waddr), .wkey_o(wkey), .wsize_o(wsize),
    .raddr_o(raddr), .rkey_i(rkey), .rsize_i(rsize)
  );

  lsac_list_ram #(.ENTRIES(ENTRIES), .SIZE_BITS(SIZE_BITS), .AW(AW)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wkey_i(wkey), .wsize_i(wsize),
    .raddr_i(raddr), .rkey_o(rkey), .rsize_o(rsize)
  );
endmodule
